// ===== rtl/core/prt_pkg.sv =====
// Shared types, constants and default parameter values of the protection region table.
package prt_pkg;

    // Default geometry of the table.
    localparam int SLOTS_DEF      = 8;
    localparam int PAGE_SHIFT_DEF = 12;

    // Slots below this index are fixed (text, data, stack); the rest are dynamic.
    localparam int FIRST_DYN = 3;

    // Register reset value of the region size code.
    localparam logic [4:0] SIZE_CODE_RESET = 5'd11;

    // Bit positions in the attribute word.
    localparam int ATTR_XN_BIT = 28;
    localparam int ATTR_AP_LSB = 24;
    localparam int ATTR_S_BIT  = 18;
    localparam int ATTR_C_BIT  = 17;
    localparam int ATTR_B_BIT  = 16;
    localparam int ATTR_EN_BIT = 0;

    // Input item kinds carried in tuser.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_REPLAY = 2'd2;

    // Sections of an add.
    localparam logic [1:0] SEG_DYN = 2'd3;

    // Memory types.
    localparam logic [1:0] MEM_INT_ROM = 2'd0;
    localparam logic [1:0] MEM_EXT_ROM = 2'd1;
    localparam logic [1:0] MEM_INT_RAM = 2'd2;
    localparam logic [1:0] MEM_EXT_RAM = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_REJECT    = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Operation classified by the front part.
    typedef enum logic [2:0] {
        OP_REJECT,
        OP_ADD_FIXED,
        OP_ADD_DYN,
        OP_REMOVE,
        OP_REPLAY
    } t_op;

    // Command handed from the front part to the back part.
    typedef struct packed {
        t_op         op;
        logic [1:0]  section;
        logic [31:0] paddr;
        logic [31:0] attr;
    } t_cmd;

endpackage

// ===== rtl/core/protection_region_table.sv =====
// Top level of the protection region table: front decoder, command queue and back sequencer.
//
// The block keeps a table of SLOTS protection regions. Slots 0, 1 and 2 hold the text, data
// and stack regions; the remaining slots hold dynamic pages, replaced round robin. An add
// builds a base word (page address with the slot number in bits 2:0) and an attribute word
// and emits one region write; an add of page zero, or of a dynamic page already present, is
// rejected. A remove finds the lowest slot whose base matches the page address, emits that
// region with its enable bit cleared and zeroes the slot, or reports not found. A replay
// emits every slot in order, the last result carrying tlast. Items of the unused kind are
// taken and produce nothing. The front part decodes each item into a command and places it
// in a two-entry queue, so up to two items may be accepted while the back part is busy. The
// back part takes one command at a time: in the idle state it pops the command and compares
// its page against every slot in parallel, then, once the result register is free, it updates
// the table and loads the result register; a replay emits the slots one by one through the
// single-slot read port of the table. Results leave through a register that frees as soon as
// it is taken, and the size code register may be written at any time the block is idle; it
// resets to 11 and fills attribute bits 5:1 of every later add. The table resets to all ones.
module protection_region_table
    import prt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Size code register.
    input  logic        i_cfg_wen,
    input  logic [4:0]  i_cfg_wdata,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: page_number[19:0], section[21:20], is_device[22], mem_type[24:23],
    //        may_execute[25], kernel_write[26], owner_write[27], zero[31:28]
    input  logic [31:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: slot[2:0], region_base[34:3], region_attr[66:35], zero[71:67]
    output logic [71:0] m_axis_tdata,
    // tuser: status[1:0], program_region[2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // Command path from the decoder into the queue.
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;

    // Command path from the queue into the sequencer.
    logic w_q_valid;
    logic w_pop;
    t_cmd w_q_cmd;

    prt_front #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_cmd    (w_push_cmd)
    );

    prt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    prt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// ===== rtl/core/prt_front.sv =====
// Front part: accepts input items, decodes them and builds the command for the back part.
module prt_front
    import prt_pkg::*;
#(
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: page_number[19:0], section[21:20], is_device[22], mem_type[24:23],
    //        may_execute[25], kernel_write[26], owner_write[27], zero[31:28]
    input  logic [31:0] i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic [19:0] w_page;
    logic [1:0]  w_section;
    logic        w_dev;
    logic [1:0]  w_mtype;
    logic        w_xok;
    logic        w_kwr;
    logic        w_owr;
    logic [51:0] w_shifted;
    logic [31:0] w_attr;

    assign w_page    = i_s_tdata[19:0];
    assign w_section = i_s_tdata[21:20];
    assign w_dev     = i_s_tdata[22];
    assign w_mtype   = i_s_tdata[24:23];
    assign w_xok     = i_s_tdata[25];
    assign w_kwr     = i_s_tdata[26];
    assign w_owr     = i_s_tdata[27];

    assign w_shifted = {32'd0, w_page} << PAGE_SHIFT;

    // Attribute word without the size field, which the back part adds.
    always_comb begin
        w_attr = '0;
        if (w_dev) begin
            w_attr[ATTR_B_BIT] = 1'b1;
            w_attr[ATTR_S_BIT] = 1'b1;
        end else begin
            unique case (w_mtype)
                MEM_INT_ROM, MEM_EXT_ROM: begin
                    w_attr[ATTR_C_BIT] = 1'b1;
                end
                MEM_INT_RAM: begin
                    w_attr[ATTR_C_BIT] = 1'b1;
                    w_attr[ATTR_S_BIT] = 1'b1;
                end
                MEM_EXT_RAM: begin
                    w_attr[ATTR_C_BIT] = 1'b1;
                    w_attr[ATTR_B_BIT] = 1'b1;
                    w_attr[ATTR_S_BIT] = 1'b1;
                end
                default: begin
                    w_attr[ATTR_C_BIT] = 1'b1;
                end
            endcase
        end
        w_attr[ATTR_XN_BIT]     = ~w_xok;
        w_attr[ATTR_AP_LSB + 2] = ~w_kwr & ~w_owr;
        w_attr[ATTR_AP_LSB + 1] = 1'b1;
        w_attr[ATTR_AP_LSB]     = w_owr;
        w_attr[ATTR_EN_BIT]     = 1'b1;
    end

    always_comb begin
        o_q_cmd.section = w_section;
        o_q_cmd.paddr   = w_shifted[31:0];
        o_q_cmd.attr    = w_attr;
        priority if (i_s_tuser == KIND_ADD && w_page == '0) begin
            o_q_cmd.op = OP_REJECT;
        end else if (i_s_tuser == KIND_ADD && w_section == SEG_DYN) begin
            o_q_cmd.op = OP_ADD_DYN;
        end else if (i_s_tuser == KIND_ADD) begin
            o_q_cmd.op = OP_ADD_FIXED;
        end else if (i_s_tuser == KIND_REMOVE) begin
            o_q_cmd.op = OP_REMOVE;
        end else begin
            o_q_cmd.op = OP_REPLAY;
        end
    end

    // The unused kind is taken and dropped without reaching the queue.
    assign o_s_tready = ~i_q_full;
    assign o_q_push   = i_s_tvalid & ~i_q_full &
                        (i_s_tuser == KIND_ADD || i_s_tuser == KIND_REMOVE ||
                         i_s_tuser == KIND_REPLAY);

endmodule

// ===== rtl/core/prt_queue.sv =====
// Two-entry command queue between the front and back parts.
module prt_queue
    import prt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

// ===== rtl/core/prt_back.sv =====
// Back part: region table, command sequencer and result register.
module prt_back
    import prt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: slot[2:0], region_base[34:3], region_attr[66:35], zero[71:67]
    output logic [71:0] o_m_tdata,
    // tuser: status[1:0], program_region[2]
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int SW    = $clog2(SLOTS);
    localparam int DYN_N = SLOTS - FIRST_DYN;
    localparam int DYN_W = (DYN_N > 1) ? $clog2(DYN_N) : 1;
    localparam logic [SLOTS-1:0] DYN_MASK = {SLOTS{1'b1}} << FIRST_DYN;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPLAY
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [SLOTS-1:0] r_match;
    logic [SW-1:0]    r_cnt;
    logic [DYN_W-1:0] r_nd;
    logic [4:0]       r_size;
    logic [31:0]      r_base [SLOTS];
    logic [31:0]      r_attr [SLOTS];

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [2:0]       r_out_slot;
    logic [31:0]      r_out_base;
    logic [31:0]      r_out_attr;
    logic             r_out_prog;
    logic             r_out_last;

    logic             w_out_free;
    logic             w_emit;
    logic [SW-1:0]    w_rm_idx;
    logic [SW-1:0]    w_rd_idx;
    logic [SW-1:0]    w_dyn_idx;
    logic [SW-1:0]    w_fix_idx;
    logic [31:0]      w_rd_base;
    logic [31:0]      w_rd_attr;
    logic [31:0]      w_full_attr;
    logic             w_dup;

    assign w_out_free = ~r_out_valid | i_m_tready;
    assign w_emit     = w_out_free & ((r_state == S_EXEC) | (r_state == S_REPLAY));
    assign o_q_pop    = (r_state == S_IDLE) & i_q_valid;

    // Lowest matching slot wins on a remove.
    always_comb begin
        w_rm_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_rm_idx = SW'(i);
            end
        end
    end

    assign w_rd_idx    = (r_state == S_REPLAY) ? r_cnt : w_rm_idx;
    assign w_rd_base   = r_base[w_rd_idx];
    assign w_rd_attr   = r_attr[w_rd_idx];
    assign w_dyn_idx   = SW'(FIRST_DYN) + SW'(r_nd);
    assign w_fix_idx   = SW'(r_cmd.section);
    assign w_full_attr = r_cmd.attr | {26'd0, r_size, 1'b0};
    assign w_dup       = |(r_match & DYN_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_CODE_RESET;
        end else if (i_cfg_wen) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_nd        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_base[i] <= '1;
                r_attr[i] <= '1;
            end
        end else begin
            // A new result replaces the one just taken; otherwise a taken result empties
            // the register.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        for (int i = 0; i < SLOTS; i++) begin
                            r_match[i] <= (r_base[i][31:5] == i_q_cmd.paddr[31:5]);
                        end
                        r_cnt   <= '0;
                        r_state <= (i_q_cmd.op == OP_REPLAY) ? S_REPLAY : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_out_last <= 1'b1;
                        r_state    <= S_IDLE;
                        unique case (r_cmd.op)
                            OP_ADD_FIXED: begin
                                r_base[w_fix_idx] <= r_cmd.paddr | 32'(w_fix_idx);
                                r_attr[w_fix_idx] <= w_full_attr;
                                r_out_status      <= STATUS_DONE;
                                r_out_slot        <= 3'(w_fix_idx);
                                r_out_base        <= r_cmd.paddr | 32'(w_fix_idx);
                                r_out_attr        <= w_full_attr;
                                r_out_prog        <= 1'b1;
                            end
                            OP_ADD_DYN: begin
                                if (w_dup) begin
                                    r_out_status <= STATUS_REJECT;
                                    r_out_slot   <= '0;
                                    r_out_base   <= '0;
                                    r_out_attr   <= '0;
                                    r_out_prog   <= 1'b0;
                                end else begin
                                    r_base[w_dyn_idx] <= r_cmd.paddr | 32'(w_dyn_idx);
                                    r_attr[w_dyn_idx] <= w_full_attr;
                                    r_out_status      <= STATUS_DONE;
                                    r_out_slot        <= 3'(w_dyn_idx);
                                    r_out_base        <= r_cmd.paddr | 32'(w_dyn_idx);
                                    r_out_attr        <= w_full_attr;
                                    r_out_prog        <= 1'b1;
                                    r_nd <= (r_nd == DYN_W'(DYN_N - 1)) ? '0 : r_nd + 1'b1;
                                end
                            end
                            OP_REMOVE: begin
                                if (|r_match) begin
                                    r_base[w_rm_idx] <= '0;
                                    r_attr[w_rm_idx] <= '0;
                                    r_out_status     <= STATUS_DONE;
                                    r_out_slot       <= 3'(w_rm_idx);
                                    r_out_base       <= w_rd_base;
                                    r_out_attr       <= w_rd_attr & ~32'(1 << ATTR_EN_BIT);
                                    r_out_prog       <= 1'b1;
                                end else begin
                                    r_out_status <= STATUS_NOT_FOUND;
                                    r_out_slot   <= '0;
                                    r_out_base   <= '0;
                                    r_out_attr   <= '0;
                                    r_out_prog   <= 1'b0;
                                end
                            end
                            default: begin
                                r_out_status <= STATUS_REJECT;
                                r_out_slot   <= '0;
                                r_out_base   <= '0;
                                r_out_attr   <= '0;
                                r_out_prog   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_REPLAY: begin
                    if (w_out_free) begin
                        r_out_status <= STATUS_DONE;
                        r_out_slot   <= 3'(r_cnt);
                        r_out_base   <= w_rd_base;
                        r_out_attr   <= w_rd_attr;
                        r_out_prog   <= 1'b1;
                        r_out_last   <= (r_cnt == SW'(SLOTS - 1));
                        if (r_cnt == SW'(SLOTS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_attr, r_out_base, r_out_slot};
    assign o_m_tuser  = {r_out_prog, r_out_status};
    assign o_m_tlast  = r_out_last;

endmodule
